/* rtl/sia_pkg.sv */
// Package for the sorted insertion array.
// Shared operation codes, status codes, field widths and the cell control word.
// No dependencies.
package sia_pkg;

    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int IDX_IN_W  = 4;
    localparam int STATUS_W  = 2;
    localparam int POS_OUT_W = 4;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic push;
        logic remove;
    } t_cell_ctl;

endpackage

/* rtl/sia_cell.sv */
// One slot of the sorted array: holds an entry, compares it with the
// incoming word and shifts with its neighbors. Depends on sia_pkg.
module sia_cell
    import sia_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic                     i_valid,      // slot below stored count
    input  logic                     i_del,        // slot at or above remove index
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_left_gt,
    input  logic signed [DATA_W-1:0] i_left_data,
    input  logic signed [DATA_W-1:0] i_right_data,
    output logic                     o_gt,
    output logic                     o_ins,
    output logic signed [DATA_W-1:0] o_data
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    // Empty slots count as greater, so the first greater slot is the insert point.
    assign o_gt   = !i_valid || (r_data > i_value);
    assign o_ins  = o_gt && !i_left_gt;
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.push) begin
            if (i_left_gt) begin
                n_data = i_left_data;
            end else if (o_gt) begin
                n_data = i_value;
            end
        end else if (i_ctl.remove && i_del) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

/* rtl/sorted_insertion_array.sv */
// Sorted insertion array: ascending store of DEPTH signed words in a row of cells.
// The result strobe rises in the cycle after start. Throughput: one word per cycle;
// every cell compares and shifts in the same cycle, busy never rises.
// Reset (synchronous, active low) empties the store and drops any pending result;
// entry contents are not cleared. The receiver cannot stall results.
// Depends on sia_pkg and sia_cell.
module sorted_insertion_array
    import sia_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [FUNC_W-1:0]           i_func,
    input  logic signed [DATA_W-1:0]    i_value,
    input  logic [IDX_IN_W-1:0]         i_entry_index,
    output logic                        o_valid,
    output logic [STATUS_W-1:0]         o_status,
    output logic [POS_OUT_W-1:0]        o_position,
    output logic [CNT_OUT_W-1:0]        o_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_valid;
    logic [STATUS_W-1:0]      r_status;
    logic [POS_OUT_W-1:0]     r_position;
    logic [CNT_OUT_W-1:0]     r_count_out;

    t_status                  w_status;
    t_cell_ctl                w_ctl;
    logic [IW-1:0]            w_pos;
    logic                     w_accept;

    logic [DEPTH-1:0]         w_gt;
    logic [DEPTH-1:0]         w_ins;
    logic [DEPTH-1:0]         w_valid;
    logic [DEPTH-1:0]         w_del;
    logic signed [DATA_W-1:0] w_data [DEPTH];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                     w_left_gt;
            logic signed [DATA_W-1:0] w_left_data;
            logic signed [DATA_W-1:0] w_right_data;

            assign w_valid[g] = (g < int'(r_count));
            assign w_del[g]   = (g >= int'(i_entry_index));

            if (g == 0) begin : g_first
                assign w_left_gt   = 1'b0;
                assign w_left_data = '0;
            end else begin : g_mid
                assign w_left_gt   = w_gt[g-1];
                assign w_left_data = w_data[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign w_right_data = '0;
            end else begin : g_inner
                assign w_right_data = w_data[g+1];
            end

            sia_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_valid      (w_valid[g]),
                .i_del        (w_del[g]),
                .i_value      (i_value),
                .i_left_gt    (w_left_gt),
                .i_left_data  (w_left_data),
                .i_right_data (w_right_data),
                .o_gt         (w_gt[g]),
                .o_ins        (w_ins[g]),
                .o_data       (w_data[g])
            );
        end
    endgenerate

    // Insert flags are one-hot; OR the slot numbers together.
    always_comb begin
        w_pos = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_ins[k]) begin
                w_pos = w_pos | IW'(k);
            end
        end
    end

    always_comb begin
        w_status = ST_OK;
        w_ctl    = '0;
        n_count  = r_count;
        unique case (t_func'(i_func))
            FUNC_PUSH: begin
                if (int'(r_count) >= DEPTH) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.push = w_accept;
                    n_count    = r_count + CW'(1);
                end
            end
            FUNC_POP: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            FUNC_REMOVE: begin
                if (int'(i_entry_index) >= int'(r_count)) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.remove = w_accept;
                    n_count      = r_count - CW'(1);
                end
            end
            FUNC_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= w_status;
            r_position  <= (w_ctl.push) ? POS_OUT_W'(w_pos) : '0;
            r_count_out <= CNT_OUT_W'(n_count);
        end
    end

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_position = r_position;
    assign o_count    = r_count_out;

endmodule

/* dv/sorted_insertion_array_tb.sv */
// Self-checking testbench for sorted_insertion_array: push, pop, remove and clear
// words checked against an in-bench model of the ascending store.
// Depends on sia_pkg and the RTL of sorted_insertion_array.
`timescale 1ns / 100ps

module sorted_insertion_array_tb
    import sia_pkg::*;
();

    localparam int DEPTH      = 16;
    localparam int IDLE_LIMIT = 1000;
    localparam int N_RANDOM   = 610;

    typedef struct {
        t_func                    func;
        logic signed [DATA_W-1:0] value;
        logic [IDX_IN_W-1:0]      idx;
        bit                       drain;   // hold off until all results are back
    } t_op_word;

    typedef struct {
        t_status               status;
        logic [POS_OUT_W-1:0]  position;
        logic [CNT_OUT_W-1:0]  count;
    } t_op_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [FUNC_W-1:0]        i_func = FUNC_CLEAR;
    logic signed [DATA_W-1:0] i_value = '0;
    logic [IDX_IN_W-1:0]      i_entry_index = '0;
    logic                     o_valid;
    logic [STATUS_W-1:0]      o_status;
    logic [POS_OUT_W-1:0]     o_position;
    logic [CNT_OUT_W-1:0]     o_count;

    t_op_word   pending_words[$];
    t_op_result expected_results[$];
    int         errors = 0;

    // model of the store
    logic signed [DATA_W-1:0] sorted_entries[DEPTH];
    int                       n_stored = 0;

    // driver state
    t_op_word   cur_word;
    t_op_word   next_word;
    t_op_result pred;
    bit         taken;
    int         burst_left = 0;
    int         gap_left = 0;

    // monitor / watchdog state
    t_op_result want;
    int         idle_cycles = 0;

    // generator state: only the count matters for shaping the sequences
    int gen_count = 0;
    int n_random = 0;

    sorted_insertion_array #(.DEPTH(DEPTH)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_value       (i_value),
        .i_entry_index (i_entry_index),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_count       (o_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic apply_to_store(input t_op_word w, output t_op_result r);
        int  slot;
        bit  found;
        r.status   = ST_OK;
        r.position = '0;
        case (w.func)
            FUNC_PUSH: begin
                if (n_stored >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot  = n_stored;
                    found = 1'b0;
                    for (int i = 0; i < n_stored; i++) begin
                        if (!found && sorted_entries[i] > w.value) begin
                            slot  = i;
                            found = 1'b1;
                        end
                    end
                    for (int i = n_stored; i > slot; i--)
                        sorted_entries[i] = sorted_entries[i-1];
                    sorted_entries[slot] = w.value;
                    n_stored++;
                    r.position = slot[POS_OUT_W-1:0];
                end
            end
            FUNC_POP: begin
                if (n_stored == 0)
                    r.status = ST_EMPTY;
                else
                    n_stored--;
            end
            FUNC_REMOVE: begin
                if (int'(w.idx) >= n_stored) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int i = int'(w.idx); i + 1 < n_stored; i++)
                        sorted_entries[i] = sorted_entries[i+1];
                    n_stored--;
                end
            end
            default: n_stored = 0;
        endcase
        r.count = n_stored[CNT_OUT_W-1:0];
    endtask

    task automatic queue_word(input t_func f, input logic signed [DATA_W-1:0] v,
                              input logic [IDX_IN_W-1:0] x, input bit hold);
        t_op_word w;
        w.func  = f;
        w.value = v;
        w.idx   = x;
        w.drain = hold;
        pending_words.push_back(w);
        case (f)
            FUNC_PUSH:   if (gen_count < DEPTH) gen_count++;
            FUNC_POP:    if (gen_count > 0) gen_count--;
            FUNC_REMOVE: if (int'(x) < gen_count) gen_count--;
            default:     gen_count = 0;
        endcase
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3, 4: return int'($urandom_range(0, 16)) - 8;   // dense range, many ties
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_IN_W-1:0] pick_index();
        if (gen_count > 0 && $urandom_range(0, 4) != 0)
            return IDX_IN_W'($urandom_range(0, gen_count - 1));
        return IDX_IN_W'($urandom_range(0, 15));
    endfunction

    // Driver: holds a word until accepted, then takes the next in bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                apply_to_store(cur_word, pred);
                expected_results.push_back(pred);
            end
            if (start && !taken) begin
                // keep presenting the same word
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_words.size() > 0 &&
                         !(pending_words[0].drain && expected_results.size() != 0)) begin
                next_word = pending_words.pop_front();
                cur_word  = next_word;
                i_func        <= next_word.func;
                i_value       <= next_word.value;
                i_entry_index <= next_word.idx;
                start         <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    case ($urandom_range(0, 19))
                        0:             gap_left = $urandom_range(20, 40);
                        1, 2, 3, 4, 5: gap_left = 0;
                        default:       gap_left = $urandom_range(1, 6);
                    endcase
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result must match the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d position %0d count %0d",
                       o_status, o_position, o_count);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    errors++;
                end
                if (o_position !== want.position) begin
                    $error("position: expected %0d, actual %0d", want.position, o_position);
                    errors++;
                end
                if (o_count !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, o_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int seg_mode;
        int seg_len;
        int roll;

        // directed words: empty cases, extremes, ties, range error, then fill past full
        queue_word(FUNC_CLEAR, '0, '0, 1'b0);
        queue_word(FUNC_POP, '0, '0, 1'b0);
        queue_word(FUNC_REMOVE, '0, 4'd0, 1'b0);
        queue_word(FUNC_PUSH, 32'sh7FFF_FFFF, 4'hF, 1'b0);
        queue_word(FUNC_PUSH, 32'sh8000_0000, '0, 1'b0);
        queue_word(FUNC_PUSH, 32'sd0, '0, 1'b0);
        queue_word(FUNC_PUSH, 32'sd0, '0, 1'b0);
        queue_word(FUNC_PUSH, -32'sd1, '0, 1'b0);
        queue_word(FUNC_REMOVE, '0, 4'd15, 1'b0);
        queue_word(FUNC_REMOVE, '0, 4'd2, 1'b1);
        queue_word(FUNC_POP, '0, '0, 1'b0);
        for (int i = 0; i < 14; i++)
            queue_word(FUNC_PUSH, pick_value(), '0, 1'b0);
        queue_word(FUNC_PUSH, 32'sh5A5A_5A5A, '0, 1'b0);   // store is full here
        queue_word(FUNC_REMOVE, '0, 4'd15, 1'b0);

        while (n_random < N_RANDOM) begin
            seg_mode = $urandom_range(0, 9);
            seg_len  = $urandom_range(5, 40);
            for (int k = 0; k < seg_len; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    queue_word(FUNC_CLEAR, $urandom, IDX_IN_W'($urandom), 1'b0);
                end else if (seg_mode <= 3) begin
                    // filling: mostly pushes, runs into the full case
                    if (roll < 87)
                        queue_word(FUNC_PUSH, pick_value(), IDX_IN_W'($urandom), 1'b0);
                    else if (roll < 92)
                        queue_word(FUNC_POP, $urandom, IDX_IN_W'($urandom), 1'b0);
                    else
                        queue_word(FUNC_REMOVE, $urandom, pick_index(), 1'b0);
                end else if (seg_mode <= 6) begin
                    // draining: pops and removes down to empty
                    if (roll < 17)
                        queue_word(FUNC_PUSH, pick_value(), IDX_IN_W'($urandom), 1'b0);
                    else if (roll < 57)
                        queue_word(FUNC_POP, $urandom, IDX_IN_W'($urandom), 1'b0);
                    else
                        queue_word(FUNC_REMOVE, $urandom, pick_index(), 1'b0);
                end else begin
                    if (roll < 45)
                        queue_word(FUNC_PUSH, pick_value(), IDX_IN_W'($urandom), 1'b0);
                    else if (roll < 65)
                        queue_word(FUNC_POP, $urandom, IDX_IN_W'($urandom), 1'b0);
                    else
                        queue_word(FUNC_REMOVE, $urandom, pick_index(), 1'b0);
                end
                if (k == 0 && $urandom_range(0, 7) == 0)
                    pending_words[$].drain = 1'b1;
                n_random++;
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || start || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
